// ===== hw/rtl/lexdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// lexdfa_pkg
// Character classes, automaton state and token codes, and the classify,
// accept and transition functions of the lexer automaton.
// ----------------------------------------------------------------------------
`default_nettype none

package lexdfa_pkg;

  typedef logic [7:0] char_t;
  typedef logic [5:0] state_t;
  typedef logic [5:0] token_t;

  // character classes
  typedef enum logic [4:0] {
    C_OTHER, C_DIGIT, C_LETTER, C_BLANK, C_NL, C_SEMI, C_LP, C_RP,
    C_LB, C_RB, C_EQ, C_PLUS, C_MINUS, C_STAR, C_SLASH, C_LT, C_GT,
    C_NOT, C_AND, C_OR, C_QUES, C_COLON, C_EOF
  } class_t;

  // automaton states
  localparam state_t S_START     = 6'd0;
  localparam state_t S_DEAD      = 6'd1;
  localparam state_t S_INT       = 6'd2;
  localparam state_t S_IDENT     = 6'd3;
  localparam state_t S_LPAREN    = 6'd4;
  localparam state_t S_RPAREN    = 6'd5;
  localparam state_t S_LBRACE    = 6'd6;
  localparam state_t S_RBRACE    = 6'd7;
  localparam state_t S_ASSIGN    = 6'd8;
  localparam state_t S_EQ        = 6'd9;
  localparam state_t S_PLUS      = 6'd10;
  localparam state_t S_NEG       = 6'd11;
  localparam state_t S_SLASH     = 6'd12;
  localparam state_t S_QUES      = 6'd13;
  localparam state_t S_COLON     = 6'd14;
  localparam state_t S_LCMT      = 6'd15;
  localparam state_t S_BCMT      = 6'd16;
  localparam state_t S_BCMT_STAR = 6'd17;
  localparam state_t S_STAR      = 6'd18;
  localparam state_t S_LT        = 6'd19;
  localparam state_t S_LE        = 6'd20;
  localparam state_t S_SHL       = 6'd21;
  localparam state_t S_GT        = 6'd22;
  localparam state_t S_GE        = 6'd23;
  localparam state_t S_SHR       = 6'd24;
  localparam state_t S_NOT       = 6'd25;
  localparam state_t S_NE        = 6'd26;
  localparam state_t S_SEMI      = 6'd27;
  localparam state_t S_EOF       = 6'd28;
  localparam state_t S_AMP       = 6'd29;
  localparam state_t S_BAR       = 6'd30;
  localparam state_t S_LAND      = 6'd31;
  localparam state_t S_LOR       = 6'd32;
  localparam state_t S_ADD_ASN   = 6'd33;
  localparam state_t S_SUB_ASN   = 6'd34;
  localparam state_t S_MINUS     = 6'd35;
  localparam state_t S_MUL_ASN   = 6'd36;
  localparam state_t S_DIV_ASN   = 6'd37;
  localparam state_t S_INC       = 6'd38;
  localparam state_t S_DEC       = 6'd39;
  localparam state_t S_POW       = 6'd40;

  // token kinds
  localparam token_t TOK_BAD     = 6'd0;
  localparam token_t TOK_IDENT   = 6'd1;
  localparam token_t TOK_INT     = 6'd2;
  localparam token_t TOK_SEMI    = 6'd3;
  localparam token_t TOK_LPAREN  = 6'd4;
  localparam token_t TOK_RPAREN  = 6'd5;
  localparam token_t TOK_LBRACE  = 6'd6;
  localparam token_t TOK_RBRACE  = 6'd7;
  localparam token_t TOK_LT      = 6'd8;
  localparam token_t TOK_LE      = 6'd9;
  localparam token_t TOK_GT      = 6'd10;
  localparam token_t TOK_GE      = 6'd11;
  localparam token_t TOK_EQ      = 6'd12;
  localparam token_t TOK_NE      = 6'd13;
  localparam token_t TOK_NOT     = 6'd14;
  localparam token_t TOK_NEG     = 6'd15;
  localparam token_t TOK_AMP     = 6'd16;
  localparam token_t TOK_BAR     = 6'd17;
  localparam token_t TOK_LAND    = 6'd18;
  localparam token_t TOK_LOR     = 6'd19;
  localparam token_t TOK_SHL     = 6'd20;
  localparam token_t TOK_SHR     = 6'd21;
  localparam token_t TOK_ASSIGN  = 6'd22;
  localparam token_t TOK_PLUS    = 6'd23;
  localparam token_t TOK_MINUS   = 6'd24;
  localparam token_t TOK_STAR    = 6'd25;
  localparam token_t TOK_SLASH   = 6'd26;
  localparam token_t TOK_ADD_ASN = 6'd27;
  localparam token_t TOK_SUB_ASN = 6'd28;
  localparam token_t TOK_MUL_ASN = 6'd29;
  localparam token_t TOK_DIV_ASN = 6'd30;
  localparam token_t TOK_INC     = 6'd31;
  localparam token_t TOK_DEC     = 6'd32;
  localparam token_t TOK_POW     = 6'd33;
  localparam token_t TOK_QUES    = 6'd34;
  localparam token_t TOK_COLON   = 6'd35;
  localparam token_t TOK_EOF     = 6'd36;

  // sort one byte into its class
  function automatic class_t classify(input char_t c);
    class_t k;
    k = C_OTHER;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      k = C_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      k = C_LETTER;
    end else begin
      unique case (c)
        8'h20, 8'h09: k = C_BLANK;  // space, tab
        8'h0A:        k = C_NL;
        8'h3B:        k = C_SEMI;   // ;
        8'h28:        k = C_LP;     // (
        8'h29:        k = C_RP;     // )
        8'h7B:        k = C_LB;     // {
        8'h7D:        k = C_RB;     // }
        8'h3D:        k = C_EQ;     // =
        8'h2B:        k = C_PLUS;   // +
        8'h2D:        k = C_MINUS;  // -
        8'h2A:        k = C_STAR;   // *
        8'h2F:        k = C_SLASH;  // /
        8'h3C:        k = C_LT;     // <
        8'h3E:        k = C_GT;     // >
        8'h21:        k = C_NOT;    // !
        8'h26:        k = C_AND;    // &
        8'h7C:        k = C_OR;     // |
        8'h3F:        k = C_QUES;   // ?
        8'h3A:        k = C_COLON;  // :
        8'hFF:        k = C_EOF;
        default:      k = C_OTHER;
      endcase
    end
    return k;
  endfunction

  // token accepted by a state
  function automatic token_t accept_tok(input state_t s);
    token_t t;
    unique case (s)
      S_INT:       t = TOK_INT;
      S_IDENT:     t = TOK_IDENT;
      S_LPAREN:    t = TOK_LPAREN;
      S_RPAREN:    t = TOK_RPAREN;
      S_LBRACE:    t = TOK_LBRACE;
      S_RBRACE:    t = TOK_RBRACE;
      S_ASSIGN:    t = TOK_ASSIGN;
      S_EQ:        t = TOK_EQ;
      S_PLUS:      t = TOK_PLUS;
      S_NEG:       t = TOK_NEG;
      S_SLASH:     t = TOK_SLASH;
      S_QUES:      t = TOK_QUES;
      S_COLON:     t = TOK_COLON;
      S_STAR:      t = TOK_STAR;
      S_LT:        t = TOK_LT;
      S_LE:        t = TOK_LE;
      S_SHL:       t = TOK_SHL;
      S_GT:        t = TOK_GT;
      S_GE:        t = TOK_GE;
      S_SHR:       t = TOK_SHR;
      S_NOT:       t = TOK_NOT;
      S_NE:        t = TOK_NE;
      S_SEMI:      t = TOK_SEMI;
      S_EOF:       t = TOK_EOF;
      S_AMP:       t = TOK_AMP;
      S_BAR:       t = TOK_BAR;
      S_LAND:      t = TOK_LAND;
      S_LOR:       t = TOK_LOR;
      S_ADD_ASN:   t = TOK_ADD_ASN;
      S_SUB_ASN:   t = TOK_SUB_ASN;
      S_MINUS:     t = TOK_MINUS;
      S_MUL_ASN:   t = TOK_MUL_ASN;
      S_DIV_ASN:   t = TOK_DIV_ASN;
      S_INC:       t = TOK_INC;
      S_DEC:       t = TOK_DEC;
      S_POW:       t = TOK_POW;
      // start, dead, comments and unused codes accept nothing
      default:     t = TOK_BAD;
    endcase
    return t;
  endfunction

  // moves out of the start state
  function automatic state_t from_start(input class_t k);
    state_t n;
    unique case (k)
      C_DIGIT:       n = S_INT;
      C_LETTER:      n = S_IDENT;
      C_BLANK, C_NL: n = S_START;
      C_LP:          n = S_LPAREN;
      C_RP:          n = S_RPAREN;
      C_LB:          n = S_LBRACE;
      C_RB:          n = S_RBRACE;
      C_EQ:          n = S_ASSIGN;
      C_PLUS:        n = S_PLUS;
      C_MINUS:       n = S_NEG;
      C_SLASH:       n = S_SLASH;
      C_QUES:        n = S_QUES;
      C_COLON:       n = S_COLON;
      C_STAR:        n = S_STAR;
      C_LT:          n = S_LT;
      C_GT:          n = S_GT;
      C_NOT:         n = S_NOT;
      C_SEMI:        n = S_SEMI;
      C_EOF:         n = S_EOF;
      C_AND:         n = S_AMP;
      C_OR:          n = S_BAR;
      default:       n = S_DEAD;
    endcase
    return n;
  endfunction

  // full transition function; anything not listed goes dead
  function automatic state_t move(input state_t s, input class_t k);
    state_t n;
    n = S_DEAD;
    unique case (s)
      S_START: n = from_start(k);
      S_INT:   if (k == C_DIGIT) n = S_INT;
      S_IDENT: if (k == C_DIGIT || k == C_LETTER) n = S_IDENT;
      S_ASSIGN: if (k == C_EQ) n = S_EQ;
      S_PLUS: begin
        if (k == C_EQ) n = S_ADD_ASN;
        else if (k == C_PLUS) n = S_INC;
      end
      S_NEG: begin
        if (k == C_EQ) n = S_SUB_ASN;
        else if (k == C_BLANK) n = S_MINUS;
        else if (k == C_MINUS) n = S_DEC;
      end
      S_SLASH: begin
        if (k == C_SLASH) n = S_LCMT;
        else if (k == C_STAR) n = S_BCMT;
        else if (k == C_EQ) n = S_DIV_ASN;
      end
      S_LCMT: n = (k == C_NL) ? S_START : S_LCMT;
      S_BCMT: n = (k == C_STAR) ? S_BCMT_STAR : S_BCMT;
      S_BCMT_STAR: begin
        if (k == C_STAR) n = S_BCMT_STAR;
        else if (k == C_SLASH) n = S_START;
        else n = S_BCMT;
      end
      S_STAR: begin
        if (k == C_EQ) n = S_MUL_ASN;
        else if (k == C_STAR) n = S_POW;
      end
      S_LT: begin
        if (k == C_EQ) n = S_LE;
        else if (k == C_LT) n = S_SHL;
      end
      S_GT: begin
        if (k == C_EQ) n = S_GE;
        else if (k == C_GT) n = S_SHR;
      end
      S_NOT: if (k == C_EQ) n = S_NE;
      S_AMP: if (k == C_AND) n = S_LAND;
      S_BAR: if (k == C_OR) n = S_LOR;
      default: n = S_DEAD;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lexer_dfa_step_top.sv =====
// ----------------------------------------------------------------------------
// lexer_dfa_step_top
// One-character-per-item lexer automaton with input and result registers.
// ----------------------------------------------------------------------------
// Each accepted item carries one character byte (0xFF is end of file) and a
// restart flag that makes the step begin from the start state. The block
// returns one result per item: the automaton state after the character and
// the token kind accepted by the state held before it (0 for none). A new
// item is taken every clock cycle. An item is held in the input register
// until its result is loaded into the result register, which offers it.
// The loop through the state register (classify, transition lookup, state
// update) sets that rate. A held result stalls the input only when both
// registers are full. After reset the held state is the start state.
`default_nettype none

module lexer_dfa_step_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lexdfa_pkg::char_t    in_char_code,
  input  wire logic                 in_restart,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lexdfa_pkg::state_t        out_next_state,
  output lexdfa_pkg::token_t        out_token_type
);

  logic                 in_vld_r;
  lexdfa_pkg::char_t    char_r;
  logic                 restart_r;
  logic                 out_vld_r;
  lexdfa_pkg::state_t   out_state_r;
  lexdfa_pkg::token_t   out_tok_r;
  lexdfa_pkg::state_t   state_r;
  lexdfa_pkg::state_t   state_nxt;
  lexdfa_pkg::state_t   from_state;
  lexdfa_pkg::token_t   tok_nxt;
  logic                 out_load;
  logic                 step;

  // handshake: result register frees when empty or taken
  assign out_load = !out_vld_r || out_ready;
  assign step     = in_vld_r && out_load;
  assign in_ready = !in_vld_r || out_load;

  // automaton step on the registered item
  always_comb begin
    from_state = restart_r ? lexdfa_pkg::S_START : state_r;
    tok_nxt    = lexdfa_pkg::accept_tok(from_state);
    state_nxt  = lexdfa_pkg::move(from_state, lexdfa_pkg::classify(char_r));
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r    <= in_char_code;
      restart_r <= in_restart;
    end
  end

  // held automaton state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lexdfa_pkg::S_START;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_state_r <= state_nxt;
      out_tok_r   <= tok_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_next_state = out_state_r;
  assign out_token_type = out_tok_r;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lexer automaton step block.
// ----------------------------------------------------------------------------
// A short table of hand-picked characters runs first: the reset state, the
// byte extremes, the dead state, end of file inside and outside comments, and
// the minus-then-blank move. Random token streams follow: identifiers,
// integers, every operator, line and block comments with arbitrary bytes,
// blank runs, noise and broken sequences. Each item goes through a local model
// of the automaton, and every result is compared with the oldest expected
// result. Both sides of the block idle at random, and once the result side
// holds off long enough to back up the input.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 ITEM_TOTAL = 750;
  localparam int                 HOLD_AT    = 300;
  localparam int                 HOLD_LEN   = 80;
  localparam lexdfa_pkg::char_t  CH_EOF     = 8'hFF;

  // one expected result
  typedef struct packed {
    lexdfa_pkg::state_t nxt;
    lexdfa_pkg::token_t tok;
  } lex_result_t;

  // one row of the directed table
  typedef struct packed {
    lexdfa_pkg::char_t  ch;
    logic               rs;
    logic               typed;
    lexdfa_pkg::state_t st;
    lexdfa_pkg::token_t tk;
  } dir_row_t;

  // directed characters; only reset, extreme and dead-state rows are typed
  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{"a",    1'b0, 1'b1, lexdfa_pkg::S_IDENT, lexdfa_pkg::TOK_BAD},
    '{"9",    1'b0, 1'b1, lexdfa_pkg::S_IDENT, lexdfa_pkg::TOK_IDENT},
    '{" ",    1'b0, 1'b1, lexdfa_pkg::S_DEAD,  lexdfa_pkg::TOK_IDENT},
    '{8'h00,  1'b0, 1'b1, lexdfa_pkg::S_DEAD,  lexdfa_pkg::TOK_BAD},
    '{CH_EOF, 1'b1, 1'b1, lexdfa_pkg::S_EOF,   lexdfa_pkg::TOK_BAD},
    '{CH_EOF, 1'b0, 1'b1, lexdfa_pkg::S_DEAD,  lexdfa_pkg::TOK_EOF},
    '{"/",    1'b1, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"*",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{CH_EOF, 1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{8'h80,  1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"*",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"*",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"/",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"-",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{" ",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"\n",   1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"/",    1'b1, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"/",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{8'hFE,  1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"\n",   1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"7",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{"0",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{";",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{">",    1'b1, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD},
    '{">",    1'b0, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD}
  };

  // operators; a zero high byte marks a single character
  localparam int N_OPS = 34;
  localparam logic [15:0] OPS [N_OPS] = '{
    {8'h00, "("}, {8'h00, ")"}, {8'h00, "{"}, {8'h00, "}"},
    {8'h00, "="}, "==",
    {8'h00, "+"}, "+=", "++",
    {8'h00, "-"}, "-=", "--", "- ",
    {8'h00, "/"}, "/=",
    {8'h00, "*"}, "*=", "**",
    {8'h00, "<"}, "<=", "<<",
    {8'h00, ">"}, ">=", ">>",
    {8'h00, "!"}, "!=",
    {8'h00, ";"},
    {8'h00, "&"}, "&&",
    {8'h00, "|"}, "||",
    {8'h00, "?"}, {8'h00, ":"},
    {8'h00, CH_EOF}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  lexdfa_pkg::char_t  in_char_code = '0;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lexdfa_pkg::state_t out_next_state;
  lexdfa_pkg::token_t out_token_type;

  // typed expectation travelling with the item on offer
  logic               drv_typed = 1'b0;
  lexdfa_pkg::state_t drv_state = lexdfa_pkg::S_START;
  lexdfa_pkg::token_t drv_tok = lexdfa_pkg::TOK_BAD;

  lex_result_t        lex_expected_q[$];
  lexdfa_pkg::state_t scan_state = lexdfa_pkg::S_START;
  int                 err_count = 0;
  int                 sent_cnt = 0;
  int                 taken_cnt = 0;
  int                 restart_cnt = 0;
  int                 res_cnt = 0;
  logic [36:0]        tok_seen = '0;
  logic [40:0]        state_seen = '0;
  logic               in_burst = 1'b0;
  logic               out_burst = 1'b0;
  logic               out_hold = 1'b0;

  lexer_dfa_step_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_state (out_next_state),
    .out_token_type (out_token_type)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sort a byte into its character class
  function automatic lexdfa_pkg::class_t char_kind(input lexdfa_pkg::char_t c);
    lexdfa_pkg::class_t k;
    k = lexdfa_pkg::C_OTHER;
    if (c >= "0" && c <= "9") begin
      k = lexdfa_pkg::C_DIGIT;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      k = lexdfa_pkg::C_LETTER;
    end else begin
      case (c)
        " ", "\t": k = lexdfa_pkg::C_BLANK;
        "\n":      k = lexdfa_pkg::C_NL;
        ";":       k = lexdfa_pkg::C_SEMI;
        "(":       k = lexdfa_pkg::C_LP;
        ")":       k = lexdfa_pkg::C_RP;
        "{":       k = lexdfa_pkg::C_LB;
        "}":       k = lexdfa_pkg::C_RB;
        "=":       k = lexdfa_pkg::C_EQ;
        "+":       k = lexdfa_pkg::C_PLUS;
        "-":       k = lexdfa_pkg::C_MINUS;
        "*":       k = lexdfa_pkg::C_STAR;
        "/":       k = lexdfa_pkg::C_SLASH;
        "<":       k = lexdfa_pkg::C_LT;
        ">":       k = lexdfa_pkg::C_GT;
        "!":       k = lexdfa_pkg::C_NOT;
        "&":       k = lexdfa_pkg::C_AND;
        "|":       k = lexdfa_pkg::C_OR;
        "?":       k = lexdfa_pkg::C_QUES;
        ":":       k = lexdfa_pkg::C_COLON;
        CH_EOF:    k = lexdfa_pkg::C_EOF;
        default:   k = lexdfa_pkg::C_OTHER;
      endcase
    end
    return k;
  endfunction

  // token kind that a state accepts
  function automatic lexdfa_pkg::token_t token_of(input lexdfa_pkg::state_t s);
    lexdfa_pkg::token_t t;
    case (s)
      lexdfa_pkg::S_INT:     t = lexdfa_pkg::TOK_INT;
      lexdfa_pkg::S_IDENT:   t = lexdfa_pkg::TOK_IDENT;
      lexdfa_pkg::S_LPAREN:  t = lexdfa_pkg::TOK_LPAREN;
      lexdfa_pkg::S_RPAREN:  t = lexdfa_pkg::TOK_RPAREN;
      lexdfa_pkg::S_LBRACE:  t = lexdfa_pkg::TOK_LBRACE;
      lexdfa_pkg::S_RBRACE:  t = lexdfa_pkg::TOK_RBRACE;
      lexdfa_pkg::S_ASSIGN:  t = lexdfa_pkg::TOK_ASSIGN;
      lexdfa_pkg::S_EQ:      t = lexdfa_pkg::TOK_EQ;
      lexdfa_pkg::S_PLUS:    t = lexdfa_pkg::TOK_PLUS;
      lexdfa_pkg::S_NEG:     t = lexdfa_pkg::TOK_NEG;
      lexdfa_pkg::S_SLASH:   t = lexdfa_pkg::TOK_SLASH;
      lexdfa_pkg::S_QUES:    t = lexdfa_pkg::TOK_QUES;
      lexdfa_pkg::S_COLON:   t = lexdfa_pkg::TOK_COLON;
      lexdfa_pkg::S_STAR:    t = lexdfa_pkg::TOK_STAR;
      lexdfa_pkg::S_LT:      t = lexdfa_pkg::TOK_LT;
      lexdfa_pkg::S_LE:      t = lexdfa_pkg::TOK_LE;
      lexdfa_pkg::S_SHL:     t = lexdfa_pkg::TOK_SHL;
      lexdfa_pkg::S_GT:      t = lexdfa_pkg::TOK_GT;
      lexdfa_pkg::S_GE:      t = lexdfa_pkg::TOK_GE;
      lexdfa_pkg::S_SHR:     t = lexdfa_pkg::TOK_SHR;
      lexdfa_pkg::S_NOT:     t = lexdfa_pkg::TOK_NOT;
      lexdfa_pkg::S_NE:      t = lexdfa_pkg::TOK_NE;
      lexdfa_pkg::S_SEMI:    t = lexdfa_pkg::TOK_SEMI;
      lexdfa_pkg::S_EOF:     t = lexdfa_pkg::TOK_EOF;
      lexdfa_pkg::S_AMP:     t = lexdfa_pkg::TOK_AMP;
      lexdfa_pkg::S_BAR:     t = lexdfa_pkg::TOK_BAR;
      lexdfa_pkg::S_LAND:    t = lexdfa_pkg::TOK_LAND;
      lexdfa_pkg::S_LOR:     t = lexdfa_pkg::TOK_LOR;
      lexdfa_pkg::S_ADD_ASN: t = lexdfa_pkg::TOK_ADD_ASN;
      lexdfa_pkg::S_SUB_ASN: t = lexdfa_pkg::TOK_SUB_ASN;
      lexdfa_pkg::S_MINUS:   t = lexdfa_pkg::TOK_MINUS;
      lexdfa_pkg::S_MUL_ASN: t = lexdfa_pkg::TOK_MUL_ASN;
      lexdfa_pkg::S_DIV_ASN: t = lexdfa_pkg::TOK_DIV_ASN;
      lexdfa_pkg::S_INC:     t = lexdfa_pkg::TOK_INC;
      lexdfa_pkg::S_DEC:     t = lexdfa_pkg::TOK_DEC;
      lexdfa_pkg::S_POW:     t = lexdfa_pkg::TOK_POW;
      default:               t = lexdfa_pkg::TOK_BAD;
    endcase
    return t;
  endfunction

  // state after one character class; unlisted moves go dead
  function automatic lexdfa_pkg::state_t next_of(input lexdfa_pkg::state_t s,
                                                 input lexdfa_pkg::class_t k);
    lexdfa_pkg::state_t n;
    n = lexdfa_pkg::S_DEAD;
    case (s)
      lexdfa_pkg::S_START: begin
        case (k)
          lexdfa_pkg::C_DIGIT:  n = lexdfa_pkg::S_INT;
          lexdfa_pkg::C_LETTER: n = lexdfa_pkg::S_IDENT;
          lexdfa_pkg::C_BLANK,
          lexdfa_pkg::C_NL:     n = lexdfa_pkg::S_START;
          lexdfa_pkg::C_LP:     n = lexdfa_pkg::S_LPAREN;
          lexdfa_pkg::C_RP:     n = lexdfa_pkg::S_RPAREN;
          lexdfa_pkg::C_LB:     n = lexdfa_pkg::S_LBRACE;
          lexdfa_pkg::C_RB:     n = lexdfa_pkg::S_RBRACE;
          lexdfa_pkg::C_EQ:     n = lexdfa_pkg::S_ASSIGN;
          lexdfa_pkg::C_PLUS:   n = lexdfa_pkg::S_PLUS;
          lexdfa_pkg::C_MINUS:  n = lexdfa_pkg::S_NEG;
          lexdfa_pkg::C_SLASH:  n = lexdfa_pkg::S_SLASH;
          lexdfa_pkg::C_QUES:   n = lexdfa_pkg::S_QUES;
          lexdfa_pkg::C_COLON:  n = lexdfa_pkg::S_COLON;
          lexdfa_pkg::C_STAR:   n = lexdfa_pkg::S_STAR;
          lexdfa_pkg::C_LT:     n = lexdfa_pkg::S_LT;
          lexdfa_pkg::C_GT:     n = lexdfa_pkg::S_GT;
          lexdfa_pkg::C_NOT:    n = lexdfa_pkg::S_NOT;
          lexdfa_pkg::C_SEMI:   n = lexdfa_pkg::S_SEMI;
          lexdfa_pkg::C_EOF:    n = lexdfa_pkg::S_EOF;
          lexdfa_pkg::C_AND:    n = lexdfa_pkg::S_AMP;
          lexdfa_pkg::C_OR:     n = lexdfa_pkg::S_BAR;
          default:              n = lexdfa_pkg::S_DEAD;
        endcase
      end
      lexdfa_pkg::S_INT: begin
        if (k == lexdfa_pkg::C_DIGIT) n = lexdfa_pkg::S_INT;
      end
      lexdfa_pkg::S_IDENT: begin
        if (k == lexdfa_pkg::C_DIGIT || k == lexdfa_pkg::C_LETTER) n = lexdfa_pkg::S_IDENT;
      end
      lexdfa_pkg::S_ASSIGN: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_EQ;
      end
      lexdfa_pkg::S_PLUS: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_ADD_ASN;
        else if (k == lexdfa_pkg::C_PLUS) n = lexdfa_pkg::S_INC;
      end
      lexdfa_pkg::S_NEG: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_SUB_ASN;
        else if (k == lexdfa_pkg::C_BLANK) n = lexdfa_pkg::S_MINUS;
        else if (k == lexdfa_pkg::C_MINUS) n = lexdfa_pkg::S_DEC;
      end
      lexdfa_pkg::S_SLASH: begin
        if (k == lexdfa_pkg::C_SLASH) n = lexdfa_pkg::S_LCMT;
        else if (k == lexdfa_pkg::C_STAR) n = lexdfa_pkg::S_BCMT;
        else if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_DIV_ASN;
      end
      // comments swallow everything up to their closing characters
      lexdfa_pkg::S_LCMT: begin
        n = (k == lexdfa_pkg::C_NL) ? lexdfa_pkg::S_START : lexdfa_pkg::S_LCMT;
      end
      lexdfa_pkg::S_BCMT: begin
        n = (k == lexdfa_pkg::C_STAR) ? lexdfa_pkg::S_BCMT_STAR : lexdfa_pkg::S_BCMT;
      end
      lexdfa_pkg::S_BCMT_STAR: begin
        if (k == lexdfa_pkg::C_STAR) n = lexdfa_pkg::S_BCMT_STAR;
        else if (k == lexdfa_pkg::C_SLASH) n = lexdfa_pkg::S_START;
        else n = lexdfa_pkg::S_BCMT;
      end
      lexdfa_pkg::S_STAR: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_MUL_ASN;
        else if (k == lexdfa_pkg::C_STAR) n = lexdfa_pkg::S_POW;
      end
      lexdfa_pkg::S_LT: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_LE;
        else if (k == lexdfa_pkg::C_LT) n = lexdfa_pkg::S_SHL;
      end
      lexdfa_pkg::S_GT: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_GE;
        else if (k == lexdfa_pkg::C_GT) n = lexdfa_pkg::S_SHR;
      end
      lexdfa_pkg::S_NOT: begin
        if (k == lexdfa_pkg::C_EQ) n = lexdfa_pkg::S_NE;
      end
      lexdfa_pkg::S_AMP: begin
        if (k == lexdfa_pkg::C_AND) n = lexdfa_pkg::S_LAND;
      end
      lexdfa_pkg::S_BAR: begin
        if (k == lexdfa_pkg::C_OR) n = lexdfa_pkg::S_LOR;
      end
      default: n = lexdfa_pkg::S_DEAD;
    endcase
    return n;
  endfunction

  // one scanner step from the held state
  function automatic lex_result_t scan_step(input lexdfa_pkg::state_t held,
                                            input lexdfa_pkg::char_t c,
                                            input logic rs);
    lex_result_t        r;
    lexdfa_pkg::state_t s;
    s = rs ? lexdfa_pkg::S_START : held;
    if (s > lexdfa_pkg::S_POW) s = lexdfa_pkg::S_DEAD;
    r.tok = token_of(s);
    r.nxt = next_of(s, char_kind(c));
    return r;
  endfunction

  task automatic report_err(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // predict on every accepted item, check every accepted result
  always @(posedge clk) begin : scoreboard
    lex_result_t pred;
    lex_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred = scan_step(scan_state, in_char_code, in_restart);
        scan_state = pred.nxt;
        want = pred;
        if (drv_typed) begin
          want.nxt = drv_state;
          want.tok = drv_tok;
        end
        lex_expected_q.push_back(want);
        taken_cnt++;
        if (in_restart) restart_cnt++;
      end
      if (out_valid && out_ready) begin
        res_cnt++;
        if (out_token_type <= lexdfa_pkg::TOK_EOF) tok_seen[out_token_type] = 1'b1;
        if (out_next_state <= lexdfa_pkg::S_POW) state_seen[out_next_state] = 1'b1;
        if (lex_expected_q.size() == 0) begin
          report_err($sformatf("result %0d with nothing expected", res_cnt));
        end else begin
          want = lex_expected_q.pop_front();
          if (out_next_state !== want.nxt)
            report_err($sformatf("result %0d next_state %0d, expected %0d",
                                 res_cnt, out_next_state, want.nxt));
          if (out_token_type !== want.tok)
            report_err($sformatf("result %0d token_type %0d, expected %0d",
                                 res_cnt, out_token_type, want.tok));
        end
      end
    end
  end

  // offer one character, after a random gap, and wait for it to be taken
  task automatic send_char(input lexdfa_pkg::char_t c, input logic rs,
                           input logic typed, input lexdfa_pkg::state_t st,
                           input lexdfa_pkg::token_t tk);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = (in_burst || out_hold) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_restart   <= rs;
    drv_typed    <= typed;
    drv_state    <= st;
    drv_tok      <= tk;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  task automatic feed(input lexdfa_pkg::char_t c, input logic rs);
    send_char(c, rs, 1'b0, lexdfa_pkg::S_START, lexdfa_pkg::TOK_BAD);
  endtask

  function automatic lexdfa_pkg::char_t any_letter();
    int n;
    n = $urandom_range(0, 51);
    return (n < 26) ? lexdfa_pkg::char_t'("A" + n) : lexdfa_pkg::char_t'("a" + n - 26);
  endfunction

  function automatic lexdfa_pkg::char_t any_digit();
    return lexdfa_pkg::char_t'("0" + $urandom_range(0, 9));
  endfunction

  // one random token, comment, blank run or burst of noise
  task automatic send_lexeme();
    int                 pick;
    int                 len;
    logic               rs;
    logic               closes;
    logic [15:0]        op;
    lexdfa_pkg::char_t  c;
    lexdfa_pkg::char_t  prev;
    pick   = $urandom_range(0, 99);
    rs     = ($urandom_range(0, 9) != 0);
    closes = 1'b1;
    len    = $urandom_range(0, 6);
    if (pick < 10) begin
      // noise: arbitrary bytes and restart bits
      repeat ($urandom_range(1, 4)) begin
        feed(lexdfa_pkg::char_t'($urandom), 1'($urandom_range(0, 1)));
      end
      closes = 1'b0;
    end else if (pick < 30) begin
      // identifier
      feed(any_letter(), rs);
      repeat (len) feed(($urandom_range(0, 2) == 0) ? any_digit() : any_letter(), 1'b0);
    end else if (pick < 43) begin
      // integer
      feed(any_digit(), rs);
      repeat (len) feed(any_digit(), 1'b0);
    end else if (pick < 73) begin
      // operator, one or two characters
      op = OPS[$urandom_range(0, N_OPS - 1)];
      if (op[15:8] == 8'h00) begin
        feed(op[7:0], rs);
      end else begin
        feed(op[15:8], rs);
        feed(op[7:0], 1'b0);
      end
    end else if (pick < 81) begin
      // line comment with any bytes but newline
      feed("/", rs);
      feed("/", 1'b0);
      repeat (len) begin
        c = lexdfa_pkg::char_t'($urandom);
        feed((c == "\n") ? lexdfa_pkg::char_t'("x") : c, 1'b0);
      end
      feed("\n", 1'b0);
      closes = ($urandom_range(0, 3) == 0);
    end else if (pick < 89) begin
      // block comment; stars inside never close it early
      feed("/", rs);
      feed("*", 1'b0);
      prev = "*";
      repeat (len) begin
        c = ($urandom_range(0, 3) == 0) ? lexdfa_pkg::char_t'("*")
                                        : lexdfa_pkg::char_t'($urandom);
        if (prev == "*" && c == "/") c = "x";
        feed(c, 1'b0);
        prev = c;
      end
      repeat ($urandom_range(1, 3)) feed("*", 1'b0);
      feed("/", 1'b0);
      closes = ($urandom_range(0, 3) == 0);
    end else begin
      // blanks and newlines
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       feed(" ", rs);
          1:       feed("\t", rs);
          default: feed("\n", rs);
        endcase
      end
      closes = 1'b0;
    end
    // a following character without restart reports the finished token
    if (closes && $urandom_range(0, 3) != 0) feed(lexdfa_pkg::char_t'($urandom), 1'b0);
  endtask

  // input side
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      send_char(DIR_TAB[i].ch, DIR_TAB[i].rs, DIR_TAB[i].typed,
                DIR_TAB[i].st, DIR_TAB[i].tk);
    end
    while (sent_cnt < ITEM_TOTAL) send_lexeme();
    in_valid  <= 1'b0;
    drv_typed <= 1'b0;

    // drain every result and let the pipeline settle
    while (res_cnt < sent_cnt) @(posedge clk);
    repeat (8) @(posedge clk);
    if (res_cnt != sent_cnt || lex_expected_q.size() != 0)
      report_err($sformatf("%0d items sent, %0d results, %0d still expected",
                           sent_cnt, res_cnt, lex_expected_q.size()));

    $display("summary: %0d characters scanned, %0d with restart, %0d results compared",
             taken_cnt, restart_cnt, res_cnt);
    $display("summary: %0d of 37 token kinds and %0d of 41 states seen on the output",
             $countones(tok_seen), $countones(state_seen));
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // result side: random stalls, bursts, and one long hold-off
  initial begin : result_side
    int stall;
    logic held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && res_cnt >= HOLD_AT) begin
        held     = 1'b1;
        out_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_hold = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", lex_expected_q.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire
